// ===== hdl/tcma_pkg.sv =====
package tcma_pkg;

  // fixed field widths of the ports
  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned AVG_W    = 10;

  // channel codes
  localparam logic CH_A = 1'b0;
  localparam logic CH_B = 1'b1;

  // sequencer phases; the fourth code acts like init
  typedef enum logic [1:0] {
    PH_INIT = 2'd0,
    PH_A    = 2'd1,
    PH_B    = 2'd2
  } phase_t;

  // per-word control carried down the pipe
  typedef struct packed {
    logic taken;
    logic start;
    logic next_ch;
    logic ch;
  } ctl_t;

endpackage

// ===== hdl/tcma_ring.sv =====
module tcma_ring #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned SW    = 10,
  parameter int unsigned SUM_W = 14
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [SW-1:0]    wr_sample,
  output logic [SUM_W-1:0] sum_new
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  logic [SW-1:0]    mem [DEPTH];
  logic [SW-1:0]    rd_r;
  logic [PW-1:0]    pos_r, pos_nxt;
  logic             wrapped_r;
  logic [SUM_W-1:0] sum_r;
  logic [SW-1:0]    oldest;

  // position advance with wrap
  always_comb begin
    pos_nxt = pos_r;
    if (wr_en) begin
      pos_nxt = (pos_r == LAST) ? '0 : pos_r + PW'(1);
    end
  end

  // before the first wrap the slot is taken as zero; the memory itself has no reset
  assign oldest  = wrapped_r ? rd_r : '0;
  assign sum_new = sum_r + SUM_W'(wr_sample) - SUM_W'(oldest);

  // sample storage; prefetch the slot that the next write replaces
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[pos_r] <= wr_sample;
    end
    rd_r <= mem[pos_nxt];
  end

  // position, wrap flag and window sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      wrapped_r <= 1'b0;
      sum_r     <= '0;
    end else if (wr_en) begin
      pos_r <= pos_nxt;
      sum_r <= sum_new;
      if (pos_r == LAST) begin
        wrapped_r <= 1'b1;
      end
    end
  end

endmodule

// ===== hdl/tcma_div.sv =====
module tcma_div #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned SUM_W = 14,
  parameter int unsigned QW    = 10
) (
  input  logic [SUM_W-1:0] sum,
  output logic [QW-1:0]    quot
);

  // floor(sum / DEPTH) as a multiply by a rounded-up reciprocal,
  // exact for every SUM_W-bit dividend
  localparam int unsigned LOG_D = $clog2(DEPTH);
  localparam int unsigned SHIFT = SUM_W + LOG_D;
  localparam int unsigned MW    = SUM_W + 1;
  localparam int unsigned PRW   = SUM_W + MW;
  localparam longint unsigned RECIP = ((64'd1 << SHIFT) + DEPTH - 1) / DEPTH;

  logic [PRW-1:0] prod;

  assign prod = PRW'(sum) * PRW'(MW'(RECIP));
  assign quot = prod[SHIFT +: QW];

endmodule

// ===== hdl/two_channel_adc_moving_average_unit.sv =====
// Channel  Handshake            Word
// in       in_valid/in_ready    in_data_ready, in_sample
// out      out_valid/out_ready  out_sample_taken, out_start_conversion,
//                               out_next_channel, out_average_a, out_average_b
//
// One word per cycle sustained while the output is not stalled; a result passes from
// stage 1 (ring update at the accepting edge) through the divide into the output register.
// Each channel's ring prefetches the slot it replaces next, so alternating words never wait.
// Reset is synchronous and clears phase, positions, sums and averages at once;
// a per-channel wrap flag stands in for clearing the rings, so no sweep.
// A stalled output holds its word; in_ready falls only when both stages are full.
module two_channel_adc_moving_average_unit #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_data_ready,
  input  logic [tcma_pkg::SAMPLE_W-1:0]   in_sample,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_sample_taken,
  output logic                            out_start_conversion,
  output logic                            out_next_channel,
  output logic [tcma_pkg::AVG_W-1:0]      out_average_a,
  output logic [tcma_pkg::AVG_W-1:0]      out_average_b
);

  localparam int unsigned SW = (SAMPLE_BITS < tcma_pkg::SAMPLE_W) ?
                               SAMPLE_BITS : tcma_pkg::SAMPLE_W;
  localparam int unsigned SUM_W = SW + $clog2(DEPTH);

  tcma_pkg::phase_t phase_r, phase_nxt;
  tcma_pkg::ctl_t   ctl, s1_ctl_r;
  logic             s1_valid_r, s1_adv, in_acc;
  logic [SUM_W-1:0] s1_sum_r, sum_new_a, sum_new_b;
  logic [SW-1:0]    smp, quot;
  logic             wr_a, wr_b;

  logic                       out_valid_r, out_taken_r, out_start_r, out_next_r;
  logic [tcma_pkg::AVG_W-1:0] avg_a_r, avg_b_r;

  // handshake
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  // phase sequencer: next state
  always_comb begin
    unique case (phase_r)
      tcma_pkg::PH_A: phase_nxt = tcma_pkg::PH_B;
      tcma_pkg::PH_B: phase_nxt = tcma_pkg::PH_A;
      default:        phase_nxt = tcma_pkg::PH_A;
    endcase
  end

  // phase sequencer: word control
  always_comb begin
    ctl = '0;
    unique case (phase_r)
      tcma_pkg::PH_A: begin
        ctl.taken   = in_data_ready;
        ctl.start   = 1'b1;
        ctl.next_ch = tcma_pkg::CH_B;
        ctl.ch      = tcma_pkg::CH_A;
      end
      tcma_pkg::PH_B: begin
        ctl.taken   = in_data_ready;
        ctl.start   = 1'b1;
        ctl.next_ch = tcma_pkg::CH_A;
        ctl.ch      = tcma_pkg::CH_B;
      end
      default: ctl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= tcma_pkg::PH_INIT;
    end else if (in_acc) begin
      phase_r <= phase_nxt;
    end
  end

  // ring writes
  assign smp  = in_sample[SW-1:0];
  assign wr_a = in_acc && ctl.taken && (ctl.ch == tcma_pkg::CH_A);
  assign wr_b = in_acc && ctl.taken && (ctl.ch == tcma_pkg::CH_B);

  tcma_ring #(.DEPTH(DEPTH), .SW(SW), .SUM_W(SUM_W)) u_ring_a (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (wr_a),
    .wr_sample (smp),
    .sum_new   (sum_new_a)
  );

  tcma_ring #(.DEPTH(DEPTH), .SW(SW), .SUM_W(SUM_W)) u_ring_b (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (wr_b),
    .wr_sample (smp),
    .sum_new   (sum_new_b)
  );

  // stage 1: control and updated sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ctl_r <= ctl;
      s1_sum_r <= (ctl.ch == tcma_pkg::CH_B) ? sum_new_b : sum_new_a;
    end
  end

  tcma_div #(.DEPTH(DEPTH), .SUM_W(SUM_W), .QW(SW)) u_div (
    .sum  (s1_sum_r),
    .quot (quot)
  );

  // stage 2: output register and channel averages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      avg_a_r     <= '0;
      avg_b_r     <= '0;
    end else begin
      if (s1_adv) begin
        out_valid_r <= 1'b1;
        if (s1_ctl_r.taken && (s1_ctl_r.ch == tcma_pkg::CH_A)) begin
          avg_a_r <= tcma_pkg::AVG_W'(quot);
        end
        if (s1_ctl_r.taken && (s1_ctl_r.ch == tcma_pkg::CH_B)) begin
          avg_b_r <= tcma_pkg::AVG_W'(quot);
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_taken_r <= s1_ctl_r.taken;
      out_start_r <= s1_ctl_r.start;
      out_next_r  <= s1_ctl_r.next_ch;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_sample_taken     = out_taken_r;
  assign out_start_conversion = out_start_r;
  assign out_next_channel     = out_next_r;
  assign out_average_a        = avg_a_r;
  assign out_average_b        = avg_b_r;

  // checks
  a_avg_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> ($stable(avg_a_r) && $stable(avg_b_r)))
    else $error("averages changed under a stalled word");

  a_phase_a_to_b: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (phase_r == tcma_pkg::PH_A)) |=> (phase_r == tcma_pkg::PH_B))
    else $error("phase did not move from A to B");

  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled while output stage empty");

endmodule
